>>> rtl/mfau_pkg.sv
// ----------------------------------------------------------------------------
// mfau_pkg: shared constants for the minifloat add/multiply unit
// Word layout, special-value flag positions and command codes.
// ----------------------------------------------------------------------------
package mfau_pkg;

  localparam int EXP_BITS_DEF  = 4;
  localparam int FRAC_BITS_DEF = 10;

  localparam int WORD_W = 31;

  // special-value flags, highest one wins on decode
  localparam int FLAG_NAN_POS  = 28;
  localparam int FLAG_PINF_POS = 29;
  localparam int FLAG_NINF_POS = 30;

  localparam logic [WORD_W-1:0] WORD_NAN  = WORD_W'(1) << FLAG_NAN_POS;
  localparam logic [WORD_W-1:0] WORD_PINF = WORD_W'(1) << FLAG_PINF_POS;
  localparam logic [WORD_W-1:0] WORD_NINF = WORD_W'(1) << FLAG_NINF_POS;

  // largest alignment shift kept exactly; the rest folds into a sticky bit
  localparam int ALIGN_CAP = 38;

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_MUL = 1'b1
  } cmd_t;

endpackage

>>> rtl/mfau_core.sv
// ----------------------------------------------------------------------------
// mfau_core: combinational minifloat add/multiply datapath
// Decodes both operands, forms the exact sum or product, truncates toward
// zero and packs the result word, with NaN/Inf rules applied last.
// ----------------------------------------------------------------------------
module mfau_core #(
  parameter int EXP_BITS  = mfau_pkg::EXP_BITS_DEF,
  parameter int FRAC_BITS = mfau_pkg::FRAC_BITS_DEF
) (
  input  logic                        cmd,
  input  logic [mfau_pkg::WORD_W-1:0] operand_a,
  input  logic [mfau_pkg::WORD_W-1:0] operand_b,
  output logic [mfau_pkg::WORD_W-1:0] result_word
);

  localparam int SIGN_POS = EXP_BITS + FRAC_BITS;
  localparam int BIAS     = (1 << (EXP_BITS - 1)) - 1;
  localparam int SW       = EXP_BITS + 8;           // signed scale width
  localparam int NW       = FRAC_BITS + 41;         // aligned significand width
  localparam int MW       = FRAC_BITS + 1;          // significand width
  localparam int QMIN     = 1 - BIAS - FRAC_BITS;   // scale of a denormal

  localparam logic signed [SW-1:0] QMIN_S = SW'(QMIN);
  localparam logic signed [SW-1:0] BIAS_S = SW'(BIAS);
  localparam logic signed [SW-1:0] CAP_S  = SW'(mfau_pkg::ALIGN_CAP);

  typedef enum logic [1:0] {
    K_FIN  = 2'd0,
    K_NAN  = 2'd1,
    K_PINF = 2'd2,
    K_NINF = 2'd3
  } kind_t;

  // ---------------- decode ----------------
  function automatic kind_t kind_of(input logic [mfau_pkg::WORD_W-1:0] w);
    kind_t k;
    k = K_FIN;
    if (w[mfau_pkg::FLAG_NINF_POS])     k = K_NINF;
    else if (w[mfau_pkg::FLAG_PINF_POS]) k = K_PINF;
    else if (w[mfau_pkg::FLAG_NAN_POS])  k = K_NAN;
    return k;
  endfunction

  function automatic logic sign_of(input logic [mfau_pkg::WORD_W-1:0] w);
    logic [mfau_pkg::WORD_W:0] t;
    t = {1'b0, w} >> SIGN_POS;
    return t[0];
  endfunction

  function automatic logic [MW-1:0] sig_of(input logic [mfau_pkg::WORD_W-1:0] w);
    logic [EXP_BITS-1:0] ef;
    ef = w[FRAC_BITS +: EXP_BITS];
    return {(ef != '0), w[FRAC_BITS-1:0]};
  endfunction

  function automatic logic signed [SW-1:0] scale_of(input logic [mfau_pkg::WORD_W-1:0] w);
    logic [EXP_BITS-1:0] ef;
    ef = w[FRAC_BITS +: EXP_BITS];
    if (ef == '0) return QMIN_S;
    return $signed(SW'({1'b0, ef})) - BIAS_S - SW'(FRAC_BITS);
  endfunction

  kind_t                  ka, kb;
  logic                   sa, sb;
  logic [MW-1:0]          ma, mb;
  logic signed [SW-1:0]   qa, qb;

  assign ka = kind_of(operand_a);
  assign kb = kind_of(operand_b);
  assign sa = sign_of(operand_a);
  assign sb = sign_of(operand_b);
  assign ma = sig_of(operand_a);
  assign mb = sig_of(operand_b);
  assign qa = scale_of(operand_a);
  assign qb = scale_of(operand_b);

  // ---------------- add path ----------------
  logic                 a_hi;
  logic                 hi_sign, lo_sign;
  logic [MW-1:0]        hi_sig, lo_sig;
  logic signed [SW-1:0] hi_q, s_full, s_cap, k_drop;
  logic [NW-1:0]        x, y, y_sh, drop_mask;
  logic                 sticky;
  logic [NW-1:0]        add_n;
  logic                 add_sign;
  logic signed [SW-1:0] add_q;

  always_comb begin
    a_hi    = (qa >= qb);
    hi_sign = a_hi ? sa : sb;
    lo_sign = a_hi ? sb : sa;
    hi_sig  = a_hi ? ma : mb;
    lo_sig  = a_hi ? mb : ma;
    hi_q    = a_hi ? qa : qb;
    s_full  = a_hi ? (qa - qb) : (qb - qa);
    if (s_full > CAP_S) begin
      s_cap  = CAP_S;
      k_drop = s_full - CAP_S;
    end else begin
      s_cap  = s_full;
      k_drop = '0;
    end
    y         = NW'(lo_sig);
    drop_mask = ~({NW{1'b1}} << $unsigned(k_drop));
    sticky    = |(y & drop_mask);
    y_sh      = y >> $unsigned(k_drop);
    x         = NW'(hi_sig) << $unsigned(s_cap);
    add_q     = hi_q - s_cap;
    if (hi_sign == lo_sign) begin
      add_n    = x + y_sh;
      add_sign = hi_sign;
    end else if (x > y_sh) begin
      add_n    = x - y_sh - NW'(sticky);
      add_sign = hi_sign;
    end else if (y_sh > x) begin
      add_n    = y_sh - x;
      add_sign = lo_sign;
    end else begin
      add_n    = '0;
      add_sign = 1'b0;
    end
  end

  // ---------------- multiply path ----------------
  logic [2*MW-1:0]      prod;
  assign prod = ma * mb;

  // ---------------- pack ----------------
  logic [NW-1:0]        n;
  logic                 n_sign;
  logic signed [SW-1:0] q, p, e, d, mag;
  logic [NW-1:0]        shifted;
  logic                 normal, ovf;
  logic [EXP_BITS-1:0]  ef_out;
  logic [31:0]          packed_w;

  always_comb begin
    if (cmd == mfau_pkg::CMD_MUL) begin
      n      = NW'(prod);
      n_sign = sa ^ sb;
      q      = qa + qb;
    end else begin
      n      = add_n;
      n_sign = add_sign;
      q      = add_q;
    end
    p = '0;
    for (int i = 0; i < NW; i++) begin
      if (n[i]) p = SW'(i);
    end
    e      = p + q;
    ovf    = (n != '0) && (e > BIAS_S);
    normal = (e >= (SW'(1) - BIAS_S));
    d      = normal ? (SW'(FRAC_BITS) - p) : (q - QMIN_S);
    mag    = d[SW-1] ? -d : d;
    shifted = d[SW-1] ? (n >> $unsigned(mag)) : (n << $unsigned(mag));
    ef_out = normal ? EXP_BITS'(e + BIAS_S) : '0;
    if (n == '0) begin
      packed_w = 32'(n_sign) << SIGN_POS;
    end else begin
      packed_w = (32'(n_sign) << SIGN_POS) | (32'(ef_out) << FRAC_BITS)
               | 32'(shifted[FRAC_BITS-1:0]);
    end
  end

  // ---------------- special values ----------------
  logic a_zero, b_zero, a_inf, b_inf;
  assign a_zero = (ka == K_FIN) && (ma == '0);
  assign b_zero = (kb == K_FIN) && (mb == '0);
  assign a_inf  = (ka == K_PINF) || (ka == K_NINF);
  assign b_inf  = (kb == K_PINF) || (kb == K_NINF);

  always_comb begin
    if (ka == K_NAN || kb == K_NAN) begin
      result_word = mfau_pkg::WORD_NAN;
    end else if (cmd == mfau_pkg::CMD_MUL) begin
      if (a_inf || b_inf) begin
        if (a_zero || b_zero)         result_word = mfau_pkg::WORD_NAN;
        else if ((ka == K_NINF) ^ (kb == K_NINF) ^ (a_inf ? sb : sa) & ~(a_inf && b_inf))
          result_word = mfau_pkg::WORD_NINF;
        else                          result_word = mfau_pkg::WORD_PINF;
      end else if (ovf) begin
        result_word = n_sign ? mfau_pkg::WORD_NINF : mfau_pkg::WORD_PINF;
      end else begin
        result_word = packed_w[mfau_pkg::WORD_W-1:0];
      end
    end else begin
      if (a_inf && b_inf) begin
        if (ka != kb)                 result_word = mfau_pkg::WORD_NAN;
        else if (ka == K_PINF)        result_word = mfau_pkg::WORD_PINF;
        else                          result_word = mfau_pkg::WORD_NINF;
      end else if (a_inf) begin
        result_word = (ka == K_PINF) ? mfau_pkg::WORD_PINF : mfau_pkg::WORD_NINF;
      end else if (b_inf) begin
        result_word = (kb == K_PINF) ? mfau_pkg::WORD_PINF : mfau_pkg::WORD_NINF;
      end else if (ovf) begin
        result_word = n_sign ? mfau_pkg::WORD_NINF : mfau_pkg::WORD_PINF;
      end else begin
        result_word = packed_w[mfau_pkg::WORD_W-1:0];
      end
    end
  end

endmodule

>>> rtl/minifloat_add_mul_unit.sv
// ----------------------------------------------------------------------------
// minifloat_add_mul_unit: registered minifloat adder/multiplier
// Adds or multiplies two minifloat words, truncating toward zero.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd (add or multiply), operand_a and operand_b and pulse start.
//   A beat is taken at each rising edge with start high and busy low; busy
//   stays low, so a new beat may be issued every cycle.
//   Each beat is captured in an input register, passes the combinational
//   datapath and lands in the result register, where result_word is shown
//   with done high for exactly one cycle.
//   Throughput is one operation per cycle; the input and result registers
//   sit around the single-pass datapath.
//   The receiver cannot stall: every result is taken in the cycle it shows.
//   Reset (rst, synchronous) drops any beat in flight and clears done.
// ----------------------------------------------------------------------------
module minifloat_add_mul_unit #(
  parameter int EXP_BITS  = mfau_pkg::EXP_BITS_DEF,
  parameter int FRAC_BITS = mfau_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd,
  input  logic [mfau_pkg::WORD_W-1:0] operand_a,
  input  logic [mfau_pkg::WORD_W-1:0] operand_b,
  output logic                        done,
  output logic [mfau_pkg::WORD_W-1:0] result_word
);

  logic                        in_valid;
  logic                        in_cmd;
  logic [mfau_pkg::WORD_W-1:0] in_a, in_b;
  logic [mfau_pkg::WORD_W-1:0] core_word;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    in_cmd      <= cmd;
    in_a        <= operand_a;
    in_b        <= operand_b;
    result_word <= core_word;
  end

  mfau_core #(
    .EXP_BITS  (EXP_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .cmd         (in_cmd),
    .operand_a   (in_a),
    .operand_b   (in_b),
    .result_word (core_word)
  );

`ifndef ASSERT_OFF
  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    start |-> ##2 done)
    else $error("result strobe missing two cycles after a beat");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(in_valid))
    else $error("result strobe without a captured beat");

  a_nan_propagates: assert property (@(posedge clk) disable iff (rst)
    in_valid && (in_a[mfau_pkg::FLAG_NAN_POS] && !in_a[mfau_pkg::FLAG_PINF_POS]
                 && !in_a[mfau_pkg::FLAG_NINF_POS])
    |=> result_word == mfau_pkg::WORD_NAN)
    else $error("NaN operand did not give NaN");
`endif

endmodule

>>> tb/tb_minifloat_add_mul_unit.sv
// ----------------------------------------------------------------------------
// tb_minifloat_add_mul_unit: self-checking bench for the minifloat unit
// Drives directed and random add/multiply beats with random start gaps,
// predicts each result word and compares it with the one shown on done.
// ----------------------------------------------------------------------------
module tb_minifloat_add_mul_unit;
  import mfau_pkg::*;

  localparam int EB   = EXP_BITS_DEF;
  localparam int FB   = FRAC_BITS_DEF;
  localparam int SPOS = EB + FB;
  localparam int BIAS = (1 << (EB - 1)) - 1;
  localparam int UPPER_W = 27 - SPOS;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    int          kind;  // 0 finite, 1 NaN, 2 +Inf, 3 -Inf
    bit          sign;
    longint unsigned sig;
    int          scale;
  } mf_val_t;

  function automatic mf_val_t unpack_word(logic [WORD_W-1:0] w);
    mf_val_t v;
    int ef;
    v.kind = 0;
    v.sign = (SPOS < WORD_W) ? w[SPOS] : 1'b0;
    v.sig = 0;
    v.scale = 0;
    if (w[FLAG_NINF_POS]) begin
      v.kind = 3;
      v.sign = 1'b1;
    end else if (w[FLAG_PINF_POS]) begin
      v.kind = 2;
      v.sign = 1'b0;
    end else if (w[FLAG_NAN_POS]) begin
      v.kind = 1;
      v.sign = 1'b0;
    end else begin
      ef = (w >> FB) & ((1 << EB) - 1);
      if (ef != 0) begin
        v.sig = (64'd1 << FB) + (w & ((1 << FB) - 1));
        v.scale = ef - BIAS - FB;
      end else begin
        v.sig = w & ((1 << FB) - 1);
        v.scale = 1 - BIAS - FB;
      end
    end
    return v;
  endfunction

  // truncate sign * n * 2^q toward zero into a word
  function automatic logic [WORD_W-1:0] round_to_word(bit sign, longint unsigned n, int q);
    longint unsigned sbit, t;
    int p, e, r;
    sbit = (SPOS < 64) ? (longint'(sign) << SPOS) : 0;
    p = 0;
    if (n == 0) return WORD_W'(sbit);
    t = n;
    while (t > 1) begin
      t >>= 1;
      p++;
    end
    e = p + q;
    if (e > BIAS) return sign ? WORD_NINF : WORD_PINF;
    if (e >= 1 - BIAS) begin
      if (p > FB) n >>= (p - FB);
      else n <<= (FB - p);
      n -= 64'd1 << FB;
      return WORD_W'(sbit | (longint'(e + BIAS) << FB) | n);
    end
    r = (1 - BIAS - FB) - q;
    if (r >= 64) n = 0;
    else if (r > 0) n >>= r;
    else n <<= -r;
    return WORD_W'(sbit | n);
  endfunction

  function automatic logic [WORD_W-1:0] mf_product(mf_val_t a, mf_val_t b);
    if (a.kind == 1 || b.kind == 1) return WORD_NAN;
    if (a.kind >= 2 || b.kind >= 2) begin
      if ((a.kind == 0 && a.sig == 0) || (b.kind == 0 && b.sig == 0)) return WORD_NAN;
      return (a.sign ^ b.sign) ? WORD_NINF : WORD_PINF;
    end
    return round_to_word(a.sign ^ b.sign, a.sig * b.sig, a.scale + b.scale);
  endfunction

  function automatic logic [WORD_W-1:0] mf_sum(mf_val_t a, mf_val_t b);
    mf_val_t hi, lo;
    longint unsigned x, y, sticky;
    int s, k;
    sticky = 0;
    if (a.kind == 1 || b.kind == 1) return WORD_NAN;
    if (a.kind >= 2 && b.kind >= 2)
      return (a.kind == b.kind) ? ((a.kind == 2) ? WORD_PINF : WORD_NINF) : WORD_NAN;
    if (a.kind >= 2) return (a.kind == 2) ? WORD_PINF : WORD_NINF;
    if (b.kind >= 2) return (b.kind == 2) ? WORD_PINF : WORD_NINF;
    if (a.scale >= b.scale) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    s = hi.scale - lo.scale;
    y = lo.sig;
    if (s > ALIGN_CAP) begin
      k = s - ALIGN_CAP;
      if (k >= 32) begin
        sticky = longint'(y != 0);
        y = 0;
      end else begin
        sticky = longint'((y & ((64'd1 << k) - 1)) != 0);
        y >>= k;
      end
      s = ALIGN_CAP;
    end
    x = hi.sig << s;
    if (hi.sign == lo.sign) return round_to_word(hi.sign, x + y, hi.scale - s);
    if (x > y) return round_to_word(hi.sign, x - y - sticky, hi.scale - s);
    if (y > x) return round_to_word(lo.sign, y - x, hi.scale - s);
    return '0;
  endfunction

  class mf_scoreboard;
    logic [WORD_W-1:0] pending_words[$];
    int errors = 0;

    function void note_beat(cmd_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
      if (op == CMD_MUL) pending_words.push_back(mf_product(unpack_word(a), unpack_word(b)));
      else pending_words.push_back(mf_sum(unpack_word(a), unpack_word(b)));
    endfunction

    function void check_result(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (pending_words.size() == 0) begin
        $error("result_word: none expected, actual %h", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        $error("result_word: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, cmd, busy, done;
  logic [WORD_W-1:0] operand_a, operand_b, result_word;
  mf_scoreboard sb;
  int idle_cycles;
  bit gaps_on;

  minifloat_add_mul_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .result_word(result_word)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // note accepted beats and check results at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_beat(cmd_t'(cmd), operand_a, operand_b);
      if (done) sb.check_result(result_word);
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random operand word biased toward interesting encodings
  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] w;
    int sel;
    sel = $urandom_range(0, 19);
    w = '0;
    w[SPOS] = 1'($urandom_range(0, 1));
    case (sel)
      0: w = WORD_NAN | WORD_W'($urandom & ((1 << 28) - 1));
      1: w = WORD_PINF | WORD_W'($urandom & ((1 << 29) - 1));
      2: w = WORD_NINF | WORD_W'($urandom & ((1 << 30) - 1));
      3: w[FB-1:0] = '0;
      4: w[FB-1:0] = FB'($urandom);
      5: w = WORD_W'($urandom);
      default: begin
        w[SPOS-1:FB] = EB'($urandom);
        w[FB-1:0] = FB'($urandom);
        if ($urandom_range(0, 3) == 0) w[27:SPOS+1] = UPPER_W'($urandom);
      end
    endcase
    return w;
  endfunction

  task automatic send_beat(cmd_t op, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [WORD_W-1:0] edge_words[$];
    cmd_t op;
    sb = new();
    idle_cycles = 0;
    gaps_on = 1;
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= 1'b0;
    operand_a <= '0;
    operand_b <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zeros, denormals, largest normal, all-ones exponent, specials
    edge_words = '{31'h0, 31'h4000, 31'h1, 31'h3ff, 31'h3bff, 31'h7bff,
                   31'h3c00, 31'h7fff, WORD_NAN, WORD_PINF, WORD_NINF, 31'h7fffffff};
    foreach (edge_words[i]) begin
      op = cmd_t'(i & 1);
      send_beat(op, edge_words[i], edge_words[(i + 5) % edge_words.size()]);
    end
    send_beat(CMD_MUL, WORD_PINF, 31'h4000);
    send_beat(CMD_ADD, WORD_PINF, WORD_NINF);
    send_beat(CMD_ADD, 31'h3c00, 31'h7c00);
    send_beat(CMD_ADD, 31'h4001, 31'h3c00);
    send_beat(CMD_ADD, 31'h4000, 31'h4000);
    send_beat(CMD_MUL, 31'h1, 31'h1);
    send_beat(CMD_MUL, 31'h3bff, 31'h3bff);
    send_beat(CMD_ADD, 31'h3bff, 31'h3bff);

    for (int n = 0; n < 1200; n++) begin
      if (n == 1000) gaps_on = 0;
      op = cmd_t'($urandom_range(0, 1));
      send_beat(op, pick_operand(), pick_operand());
    end
    start <= 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/mfau_pkg.sv
rtl/mfau_core.sv
rtl/minifloat_add_mul_unit.sv
tb/tb_minifloat_add_mul_unit.sv
